// ----- sv/sgm_pkg.sv -----
// Shared types and constants for the Sobel gradient magnitude block.
// No dependencies; every other file but sgm_ram uses these by scoped name.
package sgm_pkg;

    localparam int PIX_W     = 8;
    localparam int IMG_W     = 12;
    localparam int COL_W     = 11;
    localparam int ROW_W     = 12;
    localparam int MAG_W     = 11;
    localparam int GRAD_W    = 12;
    localparam int SQ_W      = 22;
    localparam int SQRT_STEPS = 11;
    localparam int CFG_IDX_W = 8;
    localparam int FIFO_DEPTH = 4;

    localparam logic [IMG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [IMG_W-1:0] HEIGHT_RESET = 12'd480;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } side_t;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        side_t                    side;
    } item_t;

endpackage

// ----- sv/sobel_gradient_magnitude.sv -----
// Top level of the streaming 3x3 Sobel gradient magnitude block.
// Depends on sgm_pkg, sgm_front, sgm_fifo and sgm_back.
//
//  channel  ports                                   carries
//  s_       s_valid s_ready s_pixel                 one raster pixel per beat
//  m_       m_valid m_ready m_magnitude m_out_col   one interior result per beat
//           m_out_row m_frame_last
//  cfg_     cfg_valid cfg_ready cfg_index cfg_data  register write per beat
//
// One pixel per cycle while s_ready is high; the line-store RAM read is prefetched.
// A result passes the front item register, the four-entry queue, one square stage
// and eleven square-root stages.
// Reset clears counters, window and valid bits; a fill mark makes unwritten line
// entries read as zero, so no clearing pass is needed.
// A stall on m_ready holds the root pipeline; the four-entry queue then fills
// before s_ready drops.
module sobel_gradient_magnitude #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [sgm_pkg::PIX_W-1:0]       s_pixel,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [sgm_pkg::MAG_W-1:0]       m_magnitude,
    output logic [sgm_pkg::COL_W-1:0]       m_out_col,
    output logic [sgm_pkg::ROW_W-1:0]       m_out_row,
    output logic                            m_frame_last,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sgm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sgm_pkg::IMG_W-1:0]       cfg_data
);

    logic [sgm_pkg::IMG_W-1:0] width_reg, height_reg;
    logic front_valid, front_ready, back_valid, back_ready;
    sgm_pkg::item_t front_item, back_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= sgm_pkg::WIDTH_RESET;
            height_reg <= sgm_pkg::HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == sgm_pkg::REG_IMAGE_WIDTH) begin
                width_reg <= cfg_data;
            end else if (cfg_index == sgm_pkg::REG_IMAGE_HEIGHT) begin
                height_reg <= cfg_data;
            end
        end
    end

    sgm_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .img_width  (width_reg),
        .img_height (height_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pixel    (s_pixel),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    sgm_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_item   (back_item)
    );

    sgm_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (back_valid),
        .item_ready   (back_ready),
        .item         (back_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_magnitude  (m_magnitude),
        .m_out_col    (m_out_col),
        .m_out_row    (m_out_row),
        .m_frame_last (m_frame_last)
    );

endmodule

// ----- sv/sgm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sgm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/sgm_front.sv -----
// Front end: pixel intake, position counters, line stores and 3x3 window, Sobel sums.
// Depends on sgm_pkg and sgm_ram.
module sgm_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [sgm_pkg::IMG_W-1:0]    img_width,
    input  logic [sgm_pkg::IMG_W-1:0]    img_height,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [sgm_pkg::PIX_W-1:0]    s_pixel,
    output logic                         item_valid,
    input  logic                         item_ready,
    output sgm_pkg::item_t               item
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int FW = $clog2(MAX_WIDTH + 1);
    localparam int LW = sgm_pkg::IMG_W + 1;

    logic [CW-1:0] col_reg, col_next;
    logic [sgm_pkg::ROW_W-1:0] row_reg, row_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [sgm_pkg::PIX_W-1:0] win_reg [6];
    logic item_valid_reg, item_valid_next;
    sgm_pkg::item_t item_reg, item_next;

    logic accept;
    logic [CW-1:0] rd_addr;
    logic [2*sgm_pkg::PIX_W-1:0] rd_data;
    logic stored;
    logic [sgm_pkg::PIX_W-1:0] mid, top, bot;
    logic [LW-1:0] w_use, h_use, col_p1, row_p1;
    logic col_end, row_end, emit;
    logic signed [sgm_pkg::GRAD_W-1:0] gx, gy;
    logic [CW-1:0] col_m1;

    assign accept = s_valid && s_ready;
    assign s_ready = !item_valid_reg || item_ready;
    assign rd_addr = accept ? col_next : col_reg;

    sgm_ram #(
        .WIDTH(2 * sgm_pkg::PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_lines (
        .aclk  (aclk),
        .we    (accept),
        .waddr (col_reg),
        .wdata ({bot, mid}),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb begin
        stored = FW'(col_reg) < fill_reg;
        bot = s_pixel;
        mid = stored ? rd_data[2*sgm_pkg::PIX_W-1:sgm_pkg::PIX_W] : '0;
        top = stored ? rd_data[sgm_pkg::PIX_W-1:0] : '0;

        w_use = LW'(img_width);
        if (w_use < LW'(3)) begin
            w_use = LW'(3);
        end
        if (w_use > LW'(MAX_WIDTH)) begin
            w_use = LW'(MAX_WIDTH);
        end
        h_use = LW'(img_height);
        if (h_use < LW'(3)) begin
            h_use = LW'(3);
        end

        col_p1 = LW'(col_reg) + LW'(1);
        row_p1 = LW'(row_reg) + LW'(1);
        col_end = col_p1 >= w_use;
        row_end = row_p1 >= h_use;
        emit = (col_reg >= CW'(2)) && (row_reg >= sgm_pkg::ROW_W'(2));

        gx = (sgm_pkg::GRAD_W'(top) + (sgm_pkg::GRAD_W'(mid) << 1) + sgm_pkg::GRAD_W'(bot))
           - (sgm_pkg::GRAD_W'(win_reg[0]) + (sgm_pkg::GRAD_W'(win_reg[2]) << 1)
              + sgm_pkg::GRAD_W'(win_reg[4]));
        gy = (sgm_pkg::GRAD_W'(win_reg[4]) + (sgm_pkg::GRAD_W'(win_reg[5]) << 1)
              + sgm_pkg::GRAD_W'(bot))
           - (sgm_pkg::GRAD_W'(win_reg[0]) + (sgm_pkg::GRAD_W'(win_reg[1]) << 1)
              + sgm_pkg::GRAD_W'(top));
        col_m1 = col_reg - CW'(1);

        if (col_end) begin
            col_next = '0;
            row_next = row_end ? '0 : row_reg + sgm_pkg::ROW_W'(1);
        end else begin
            col_next = col_reg + CW'(1);
            row_next = row_reg;
        end
        fill_next = (FW'(col_reg) >= fill_reg) ? FW'(col_reg) + FW'(1) : fill_reg;

        item_next.gx = gx;
        item_next.gy = gy;
        item_next.side.col = sgm_pkg::COL_W'(col_m1);
        item_next.side.row = row_reg - sgm_pkg::ROW_W'(1);
        item_next.side.last = col_end && row_end;

        if (accept) begin
            item_valid_next = emit;
        end else if (item_ready) begin
            item_valid_next = 1'b0;
        end else begin
            item_valid_next = item_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            fill_reg <= '0;
            item_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            item_valid_reg <= item_valid_next;
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
                fill_reg <= fill_next;
                win_reg[0] <= win_reg[1];
                win_reg[1] <= top;
                win_reg[2] <= win_reg[3];
                win_reg[3] <= mid;
                win_reg[4] <= win_reg[5];
                win_reg[5] <= bot;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= item_next;
        end
    end

    assign item_valid = item_valid_reg;
    assign item = item_reg;

endmodule

// ----- sv/sgm_fifo.sv -----
// Short queue of gradient items between the front end and the magnitude pipeline.
// Depends on sgm_pkg.
module sgm_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  sgm_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output sgm_pkg::item_t pop_item
);

    localparam int AW = $clog2(sgm_pkg::FIFO_DEPTH);
    localparam int NW = $clog2(sgm_pkg::FIFO_DEPTH + 1);

    sgm_pkg::item_t slot_reg [sgm_pkg::FIFO_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic push, pop;

    assign push_ready = count_reg != NW'(sgm_pkg::FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push = push_valid && push_ready;
    assign pop  = pop_valid && pop_ready;
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next = count_reg + NW'(push) - NW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- sv/sgm_back.sv -----
// Back end: squares the Sobel sums and takes the floored square root, one bit per stage.
// Depends on sgm_pkg.
module sgm_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  sgm_pkg::item_t              item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [sgm_pkg::MAG_W-1:0]   m_magnitude,
    output logic [sgm_pkg::COL_W-1:0]   m_out_col,
    output logic [sgm_pkg::ROW_W-1:0]   m_out_row,
    output logic                        m_frame_last
);

    localparam int N = sgm_pkg::SQRT_STEPS;
    localparam int SW = sgm_pkg::SQ_W;

    logic          vld_reg  [N+1];
    logic [SW-1:0] rem_reg  [N+1];
    logic [SW-1:0] root_reg [N+1];
    sgm_pkg::side_t side_reg [N+1];

    logic advance;
    logic signed [2*sgm_pkg::GRAD_W-1:0] px, py;
    logic [SW-1:0] sq;

    assign advance = !vld_reg[N] || m_ready;
    assign item_ready = advance;

    always_comb begin
        px = item.gx * item.gx;
        py = item.gy * item.gy;
        sq = SW'(px) + SW'(py);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (advance) begin
            vld_reg[0] <= item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rem_reg[0] <= sq;
            root_reg[0] <= '0;
            side_reg[0] <= item.side;
        end
    end

    for (genvar i = 1; i <= N; i++) begin : g_step
        localparam logic [SW-1:0] BIT = SW'(1) << (2 * (N - i));
        logic [SW-1:0] trial, rem_next, root_next;

        always_comb begin
            trial = root_reg[i-1] + BIT;
            if (rem_reg[i-1] >= trial) begin
                rem_next = rem_reg[i-1] - trial;
                root_next = (root_reg[i-1] >> 1) + BIT;
            end else begin
                rem_next = rem_reg[i-1];
                root_next = root_reg[i-1] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (advance) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                rem_reg[i] <= rem_next;
                root_reg[i] <= root_next;
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign m_valid = vld_reg[N];
    assign m_magnitude = sgm_pkg::MAG_W'(root_reg[N]);
    assign m_out_col = side_reg[N].col;
    assign m_out_row = side_reg[N].row;
    assign m_frame_last = side_reg[N].last;

endmodule

// ----- dv/sgm_checker.sv -----
// Scoreboard for the Sobel gradient magnitude block: watches the pixel, result and register
// channels, predicts each interior result and compares it field by field. Depends on sgm_pkg.
`timescale 1ns / 1ps
module sgm_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [sgm_pkg::PIX_W-1:0]     s_pixel,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [sgm_pkg::MAG_W-1:0]     m_magnitude,
    input  logic [sgm_pkg::COL_W-1:0]     m_out_col,
    input  logic [sgm_pkg::ROW_W-1:0]     m_out_row,
    input  logic                          m_frame_last,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [sgm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sgm_pkg::IMG_W-1:0]     cfg_data,
    output int                            mismatches,
    output int                            pending,
    output int                            results_seen
);

    localparam int DEPTH = 2048;

    typedef struct {
        logic [sgm_pkg::MAG_W-1:0] mag;
        logic [sgm_pkg::COL_W-1:0] col;
        logic [sgm_pkg::ROW_W-1:0] row;
        logic                      last;
    } edge_res_t;

    logic [sgm_pkg::IMG_W-1:0] width_reg, height_reg;
    logic [sgm_pkg::PIX_W-1:0] prev_row [DEPTH];
    logic [sgm_pkg::PIX_W-1:0] older_row [DEPTH];
    logic [sgm_pkg::PIX_W-1:0] win [6];
    int                        col_cnt, row_cnt;
    edge_res_t                 expected_q [$];

    function automatic logic [sgm_pkg::MAG_W-1:0] isqrt(input int unsigned v);
        logic [sgm_pkg::MAG_W-1:0] root;
        logic [sgm_pkg::MAG_W-1:0] trial;
        root = '0;
        for (int b = sgm_pkg::MAG_W - 1; b >= 0; b--) begin
            trial = root | (sgm_pkg::MAG_W'(1) << b);
            if (int'(trial) * int'(trial) <= v) root = trial;
        end
        return root;
    endfunction

    task automatic predict_pixel(input logic [sgm_pkg::PIX_W-1:0] px);
        int        w, h, gx, gy;
        logic [sgm_pkg::PIX_W-1:0] mid, top;
        edge_res_t res;
        w = (width_reg < 3) ? 3 : (width_reg > DEPTH) ? DEPTH : int'(width_reg);
        h = (height_reg < 3) ? 3 : int'(height_reg);
        mid = prev_row[col_cnt];
        top = older_row[col_cnt];
        if (col_cnt >= 2 && row_cnt >= 2) begin
            gx = (int'(top) + 2 * int'(mid) + int'(px))
               - (int'(win[0]) + 2 * int'(win[2]) + int'(win[4]));
            gy = (int'(win[4]) + 2 * int'(win[5]) + int'(px))
               - (int'(win[0]) + 2 * int'(win[1]) + int'(top));
            res.mag  = isqrt(gx * gx + gy * gy);
            res.col  = sgm_pkg::COL_W'(col_cnt - 1);
            res.row  = sgm_pkg::ROW_W'(row_cnt - 1);
            res.last = (col_cnt + 1 >= w) && (row_cnt + 1 >= h);
            expected_q.push_back(res);
        end
        older_row[col_cnt] = mid;
        prev_row[col_cnt]  = px;
        win[0] = win[1]; win[1] = top;
        win[2] = win[3]; win[3] = mid;
        win[4] = win[5]; win[5] = px;
        if (col_cnt + 1 >= w) begin
            col_cnt = 0;
            row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
        end else begin
            col_cnt = col_cnt + 1;
        end
    endtask

    task automatic compare_beat();
        edge_res_t e;
        results_seen++;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result beat, got mag %0d col %0d row %0d last %0b",
                     $time, m_magnitude, m_out_col, m_out_row, m_frame_last);
            mismatches++;
        end else begin
            e = expected_q.pop_front();
            if (e.mag !== m_magnitude || e.col !== m_out_col || e.row !== m_out_row
                    || e.last !== m_frame_last) begin
                $display("%0t: expected mag %0d col %0d row %0d last %0b, got %0d %0d %0d %0b",
                         $time, e.mag, e.col, e.row, e.last,
                         m_magnitude, m_out_col, m_out_row, m_frame_last);
                mismatches++;
            end
        end
    endtask

    initial begin
        mismatches   = 0;
        results_seen = 0;
        pending      = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  = sgm_pkg::WIDTH_RESET;
            height_reg = sgm_pkg::HEIGHT_RESET;
            for (int i = 0; i < DEPTH; i++) begin
                prev_row[i]  = '0;
                older_row[i] = '0;
            end
            for (int i = 0; i < 6; i++) win[i] = '0;
            col_cnt = 0;
            row_cnt = 0;
            expected_q.delete();
        end else begin
            if (m_valid && m_ready) compare_beat();
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == sgm_pkg::REG_IMAGE_WIDTH) width_reg = cfg_data;
                else if (cfg_index == sgm_pkg::REG_IMAGE_HEIGHT) height_reg = cfg_data;
            end
            if (s_valid && s_ready) predict_pixel(s_pixel);
        end
        pending = expected_q.size();
    end

endmodule

// ----- dv/sobel_gradient_magnitude_tb.sv -----
// Top of the Sobel gradient magnitude testbench: clock, reset, pixel and register stimulus
// with varied back-pressure. Depends on sgm_pkg, sgm_checker and the block itself.
`timescale 1ns / 1ps
module sobel_gradient_magnitude_tb;

    localparam logic [sgm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd7;
    localparam int SETTLE = 30;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                          aclk, aresetn;
    logic                          s_valid, s_ready;
    logic [sgm_pkg::PIX_W-1:0]     s_pixel;
    logic                          m_valid, m_ready;
    logic [sgm_pkg::MAG_W-1:0]     m_magnitude;
    logic [sgm_pkg::COL_W-1:0]     m_out_col;
    logic [sgm_pkg::ROW_W-1:0]     m_out_row;
    logic                          m_frame_last;
    logic                          cfg_valid, cfg_ready;
    logic [sgm_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [sgm_pkg::IMG_W-1:0]     cfg_data;
    int                            mismatches, pending, results_seen;
    idle_mode_t                    idle_mode;
    int                            hold_requests;
    int                            pixels_sent;

    sobel_gradient_magnitude i_dut (.*);

    sgm_checker i_checker (.*);

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    // receiver: random stalls per mode, plus long hold-offs on request
    initial begin
        int hold_cnt;
        int seen;
        hold_cnt = 0;
        seen     = 0;
        m_ready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (seen != hold_requests) begin
                seen     = hold_requests;
                hold_cnt = 80;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else if (idle_mode == IDLE_RECEIVER) begin
                m_ready <= ($urandom_range(99) >= 81);
            end else if (idle_mode == IDLE_BOTH) begin
                m_ready <= ($urandom_range(99) >= 11);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic bit sender_gap();
        if (idle_mode == IDLE_SENDER) return $urandom_range(99) < 81;
        if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 11;
        return 1'b0;
    endfunction

    task automatic push_pixel(input logic [sgm_pkg::PIX_W-1:0] px);
        while (sender_gap()) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        do @(posedge aclk); while (!s_ready);
        pixels_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [sgm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sgm_pkg::IMG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(input logic [sgm_pkg::IMG_W-1:0] w,
                             input logic [sgm_pkg::IMG_W-1:0] h);
        drain();
        write_reg(sgm_pkg::REG_IMAGE_WIDTH, w);
        write_reg(sgm_pkg::REG_IMAGE_HEIGHT, h);
    endtask

    function automatic logic [sgm_pkg::PIX_W-1:0] rand_pixel();
        if ($urandom_range(3) == 0) return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
        return sgm_pkg::PIX_W'($urandom);
    endfunction

    initial begin
        int n;
        logic [sgm_pkg::IMG_W-1:0] w, h;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_pixel       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        idle_mode     = IDLE_NONE;
        hold_requests = 0;
        pixels_sent   = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // smallest frame, steepest edges
        set_frame(12'd3, 12'd3);
        for (int i = 0; i < 9; i++) push_pixel((i == 2 || i >= 5) ? 8'hFF : 8'h00);
        for (int i = 0; i < 9; i++) push_pixel((i % 3 == 0) ? 8'hFF : 8'h00);
        // clamped sizes, ignored register index
        set_frame(12'd0, 12'd0);
        write_reg(REG_UNUSED, 12'hFFF);
        for (int i = 0; i < 10; i++) push_pixel(rand_pixel());
        set_frame(12'd3, 12'd4095);
        for (int i = 0; i < 20; i++) push_pixel(rand_pixel());
        // width beyond the store depth, then shrink while the counters are far out
        set_frame(12'd4095, 12'd3);
        for (int i = 0; i < 200; i++) push_pixel(rand_pixel());
        set_frame(12'd20, 12'd8);
        for (int i = 0; i < 75; i++) push_pixel(rand_pixel());
        set_frame(12'd5, 12'd3);
        for (int i = 0; i < 20; i++) push_pixel(rand_pixel());

        for (int ph = 0; ph < 12; ph++) begin
            w = 12'($urandom_range(3, 24));
            h = 12'($urandom_range(3, 8));
            if (ph == 3) h = 12'd4095;
            if (ph == 4) begin
                w = 12'd5;
                h = 12'd8;
            end
            if (ph == 9) w = 12'd1;
            set_frame(w, h);
            idle_mode = idle_mode_t'(ph % 4);
            if (ph == 4 || ph == 8) idle_mode = IDLE_NONE;
            n = $urandom_range(50, 70);
            for (int i = 0; i < n; i++) begin
                if (ph == 4 && i == 5) hold_requests++;
                if (ph == 6 && i == n / 2) begin
                    s_valid <= 1'b0;
                    @(negedge aclk);
                    while (pending != 0) @(negedge aclk);
                end
                push_pixel(rand_pixel());
            end
        end

        idle_mode = IDLE_NONE;
        drain();
        $display("Sent %0d pixels and checked %0d results over frames from 3x3 to clamped width,",
                 pixels_sent, results_seen);
        $display("with clamped and shrunk frame sizes, sender gaps and receiver stalls");
        if (mismatches == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
